// File: rtl/core/tcch_pkg.sv
// Shared types, constants and helper functions for the tilt-compensated compass heading block.
`timescale 1ns / 1ps
`default_nettype none

package tcch_pkg;

    localparam int ONE_Q14       = 16384;
    localparam int ATAN_ENTRIES  = 24;
    localparam int SQRT_BITS     = 15;
    localparam int SQRT_PER_CELL = 3;
    localparam int SQRT_CELLS    = SQRT_BITS / SQRT_PER_CELL;
    localparam int VEC_W         = 50;
    localparam int ANG_W         = 34;
    localparam int ROOT_W        = 30;
    localparam logic [15:0] HEADING_MAX = 16'd46079;
    localparam logic [15:0] SECTOR_Q7   = 16'd5760;
    localparam logic signed [ANG_W-1:0] DEG180_Q22 = ANG_W'(64'sd180 <<< 22);
    localparam logic signed [ANG_W-1:0] DEG360_Q22 = ANG_W'(64'sd360 <<< 22);

    // Sensor values that travel alongside the square-root cells.
    typedef struct packed {
        logic signed [15:0] sp;
        logic signed [15:0] sr;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
    } t_sens;

    // Remainder and partial root of the two cosine square roots.
    typedef struct packed {
        logic [ROOT_W-1:0] np;
        logic [ROOT_W-1:0] rp;
        logic [ROOT_W-1:0] nr;
        logic [ROOT_W-1:0] rr;
    } t_root;

    // Vector and angle state handed from one rotation cell to the next.
    typedef struct packed {
        logic                    zero;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } t_cvec;

    function automatic logic signed [15:0] clamp_unit(input logic signed [15:0] a);
        logic signed [15:0] res;
        res = a;
        if (a < -16'sd16384) res = -16'sd16384;
        if (a > 16'sd16384)  res = 16'sd16384;
        return res;
    endfunction

    // atan(2^-i) in degrees at scale 2^-22.
    function automatic logic signed [ANG_W-1:0] atan_q22(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:  v = 34'sd188743680;
            1:  v = 34'sd111421900;
            2:  v = 34'sd58872272;
            3:  v = 34'sd29884485;
            4:  v = 34'sd15000234;
            5:  v = 34'sd7507429;
            6:  v = 34'sd3754631;
            7:  v = 34'sd1877430;
            8:  v = 34'sd938729;
            9:  v = 34'sd469366;
            10: v = 34'sd234683;
            11: v = 34'sd117342;
            12: v = 34'sd58671;
            13: v = 34'sd29335;
            14: v = 34'sd14668;
            15: v = 34'sd7334;
            16: v = 34'sd3667;
            17: v = 34'sd1833;
            18: v = 34'sd917;
            19: v = 34'sd458;
            20: v = 34'sd229;
            21: v = 34'sd115;
            22: v = 34'sd57;
            23: v = 34'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tilt_compensated_compass_heading.sv
// Top level of the tilt-compensated compass heading pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Stages: clamp, square-root cells, products, sum, prerotation, rotation cells, output.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds only while a finished result waits at the output and is stalled.
// Reset (synchronous, active low) clears all valid bits; payload registers are not reset.
// The rotation chain of one cell per CORDIC step sets the latency.

module tilt_compensated_compass_heading #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire signed [15:0]   i_accel_x,
    input  wire signed [15:0]   i_accel_y,
    input  wire signed [15:0]   i_mag_x,
    input  wire signed [15:0]   i_mag_y,
    input  wire signed [15:0]   i_mag_z,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [15:0]         o_heading_deg,
    output logic [2:0]          o_sector_index
);
    import tcch_pkg::*;

    // Only the first 24 arctangent entries exist.
    localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    // Every stage moves when the output register is free or being emptied.
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Stage 1: clamp the accelerometer to one g and start both roots at 2^28 - a*a.
    logic               r_s1_vld;
    t_sens              r_s1_sens;
    t_root              r_s1_root;
    logic signed [15:0] c_sp;
    logic signed [15:0] c_sr;
    logic signed [31:0] sq_p;
    logic signed [31:0] sq_r;

    always_comb begin
        c_sp = clamp_unit(i_accel_x);
        c_sr = clamp_unit(i_accel_y);
        sq_p = 32'(c_sp) * 32'(c_sp);
        sq_r = 32'(c_sr) * 32'(c_sr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_valid;
        end
        if (en) begin
            r_s1_sens.sp <= c_sp;
            r_s1_sens.sr <= c_sr;
            r_s1_sens.mx <= i_mag_x;
            r_s1_sens.my <= i_mag_y;
            r_s1_sens.mz <= i_mag_z;
            r_s1_root.np <= ROOT_W'(29'd268435456) - ROOT_W'(sq_p[28:0]);
            r_s1_root.nr <= ROOT_W'(29'd268435456) - ROOT_W'(sq_r[28:0]);
            r_s1_root.rp <= '0;
            r_s1_root.rr <= '0;
        end
    end

    // Square-root cells: each resolves three bits of both cosines.
    logic  sq_vld  [0:SQRT_CELLS];
    t_root sq_root [0:SQRT_CELLS];
    t_sens sq_sens [0:SQRT_CELLS];

    assign sq_vld[0]  = r_s1_vld;
    assign sq_root[0] = r_s1_root;
    assign sq_sens[0] = r_s1_sens;

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        tcch_sqrt_cell #(
            .FIRST_K (SQRT_BITS - 1 - g * SQRT_PER_CELL)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (sq_vld[g]),
            .i_root  (sq_root[g]),
            .i_sens  (sq_sens[g]),
            .o_vld   (sq_vld[g+1]),
            .o_root  (sq_root[g+1]),
            .o_sens  (sq_sens[g+1])
        );
    end

    // Product stage A: two-factor products of field and sine or cosine.
    t_sens              ps;
    logic signed [15:0] cp;
    logic signed [15:0] cr;
    assign ps = sq_sens[SQRT_CELLS];
    assign cp = signed'({1'b0, sq_root[SQRT_CELLS].rp[14:0]});
    assign cr = signed'({1'b0, sq_root[SQRT_CELLS].rr[14:0]});

    logic               r_pa_vld;
    logic signed [31:0] r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [15:0] r_pa_sp, r_pa_cp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa_vld <= 1'b0;
        end else if (en) begin
            r_pa_vld <= sq_vld[SQRT_CELLS];
        end
        if (en) begin
            r_p1    <= 32'(ps.mx) * 32'(cp);
            r_p2    <= 32'(ps.mz) * 32'(ps.sp);
            r_p3    <= 32'(ps.mx) * 32'(ps.sr);
            r_p4    <= 32'(ps.my) * 32'(cr);
            r_p5    <= 32'(ps.mz) * 32'(ps.sr);
            r_pa_sp <= ps.sp;
            r_pa_cp <= cp;
        end
    end

    // Product stage B: the three-factor terms of yh and the sum that forms xh.
    logic               r_pb_vld;
    logic signed [47:0] r_q3, r_q5;
    logic signed [32:0] r_s12;
    logic signed [31:0] r_pb_p4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb_vld <= 1'b0;
        end else if (en) begin
            r_pb_vld <= r_pa_vld;
        end
        if (en) begin
            r_q3    <= 48'(r_p3) * 48'(r_pa_sp);
            r_q5    <= 48'(r_p5) * 48'(r_pa_cp);
            r_s12   <= 33'(r_p1) + 33'(r_p2);
            r_pb_p4 <= r_p4;
        end
    end

    // Sum stage: xh and yh at scale 2^-40.
    logic                    r_sm_vld;
    logic signed [VEC_W-1:0] r_xh, r_yh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm_vld <= 1'b0;
        end else if (en) begin
            r_sm_vld <= r_pb_vld;
        end
        if (en) begin
            r_xh <= VEC_W'(r_s12) <<< 14;
            r_yh <= VEC_W'(r_q3) + (VEC_W'(r_pb_p4) <<< 14) - VEC_W'(r_q5);
        end
    end

    // Prerotation: a vector pointing left is negated and starts at 180 degrees.
    logic  r_pr_vld;
    t_cvec r_pr_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_vld <= 1'b0;
        end else if (en) begin
            r_pr_vld <= r_sm_vld;
        end
        if (en) begin
            r_pr_vec.zero <= (r_xh == '0) && (r_yh == '0);
            if (r_xh < 0) begin
                r_pr_vec.x <= -r_xh;
                r_pr_vec.y <= -r_yh;
                r_pr_vec.z <= DEG180_Q22;
            end else begin
                r_pr_vec.x <= r_xh;
                r_pr_vec.y <= r_yh;
                r_pr_vec.z <= '0;
            end
        end
    end

    // Rotation chain: one cell per CORDIC step.
    logic  cv_vld [0:NSTEP];
    t_cvec cv_vec [0:NSTEP];

    assign cv_vld[0] = r_pr_vld;
    assign cv_vec[0] = r_pr_vec;

    for (genvar g = 0; g < NSTEP; g++) begin : g_cordic
        tcch_cordic_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (cv_vld[g]),
            .i_vec   (cv_vec[g]),
            .o_vld   (cv_vld[g+1]),
            .o_vec   (cv_vec[g+1])
        );
    end

    // Output stage: wrap into 0..360, round to Q9.7, saturate, and find the sector.
    t_cvec                   fv;
    logic signed [ANG_W-1:0] zw;
    logic signed [ANG_W-1:0] zr;
    logic [15:0]             n_heading;
    logic [2:0]              n_sector;

    always_comb begin
        fv = cv_vec[NSTEP];
        zw = (fv.z < 0) ? fv.z + DEG360_Q22 : fv.z;
        zr = (zw + ANG_W'(34'sd16384)) >>> 15;
        if (fv.zero) begin
            n_heading = '0;
        end else if (zr > ANG_W'(HEADING_MAX)) begin
            n_heading = HEADING_MAX;
        end else begin
            n_heading = zr[15:0];
        end
        n_sector = 3'd4;
        for (int k = 1; k < 8; k++) begin
            if (n_heading >= 16'(k * 5760)) n_sector = n_sector + 3'd1;
        end
    end

    logic        r_out_vld;
    logic [15:0] r_heading;
    logic [2:0]  r_sector;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= cv_vld[NSTEP];
        end
        if (en) begin
            r_heading <= n_heading;
            r_sector  <= n_sector;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_heading_deg  = r_heading;
    assign o_sector_index = r_sector;

    // The input side is held back only while a result sits in the output register.
    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> o_valid)
        else $error("input stalled without a held result");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_heading_deg <= HEADING_MAX))
        else $error("heading beyond 360 degrees");

    a_first_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_heading_deg < SECTOR_Q7)) |-> (o_sector_index == 3'd4))
        else $error("sector does not match heading");

endmodule

`default_nettype wire

// File: rtl/core/tcch_sqrt_cell.sv
// One square-root cell: three restoring root steps for both cosines.
`timescale 1ns / 1ps
`default_nettype none

module tcch_sqrt_cell #(
    parameter int FIRST_K = 14
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire                   i_vld,
    input  tcch_pkg::t_root       i_root,
    input  tcch_pkg::t_sens       i_sens,
    output logic                  o_vld,
    output tcch_pkg::t_root       o_root,
    output tcch_pkg::t_sens       o_sens
);
    import tcch_pkg::*;

    logic   r_vld;
    t_root  r_root;
    t_sens  r_sens;
    t_root  n_root;

    function automatic void root_step(input logic [ROOT_W-1:0] b,
                                      inout logic [ROOT_W-1:0] n,
                                      inout logic [ROOT_W-1:0] r);
        logic [ROOT_W-1:0] t;
        t = r + b;
        if (n >= t) begin
            n = n - t;
            r = (r >> 1) + b;
        end else begin
            r = r >> 1;
        end
    endfunction

    always_comb begin
        n_root = i_root;
        for (int j = 0; j < SQRT_PER_CELL; j++) begin
            root_step(ROOT_W'(1) << (2 * (FIRST_K - j)), n_root.np, n_root.rp);
            root_step(ROOT_W'(1) << (2 * (FIRST_K - j)), n_root.nr, n_root.rr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_root <= n_root;
            r_sens <= i_sens;
        end
    end

    assign o_vld  = r_vld;
    assign o_root = r_root;
    assign o_sens = r_sens;

endmodule

`default_nettype wire

// File: rtl/core/tcch_cordic_cell.sv
// One vectoring rotation cell of the heading arctangent chain.
`timescale 1ns / 1ps
`default_nettype none

module tcch_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  wire               i_vld,
    input  tcch_pkg::t_cvec   i_vec,
    output logic              o_vld,
    output tcch_pkg::t_cvec   o_vec
);
    import tcch_pkg::*;

    logic  r_vld;
    t_cvec r_vec;
    t_cvec n_vec;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;

    always_comb begin
        dx    = i_vec.y >>> IDX;
        dy    = i_vec.x >>> IDX;
        n_vec = i_vec;
        if (i_vec.y >= 0) begin
            n_vec.x = i_vec.x + dx;
            n_vec.y = i_vec.y - dy;
            n_vec.z = i_vec.z + atan_q22(IDX);
        end else begin
            n_vec.x = i_vec.x - dx;
            n_vec.y = i_vec.y + dy;
            n_vec.z = i_vec.z - atan_q22(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vld = r_vld;
    assign o_vec = r_vec;

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the tilt-compensated compass heading pipeline.
`timescale 1ns / 1ps

module testbench;
    import tcch_pkg::*;

    // The instance uses the default rotation count; the heading predictor mirrors it.
    localparam int ROT_STEPS  = 16;
    localparam int DRAIN_WAIT = 11 + ROT_STEPS + 20;
    localparam int RAND_REQS  = 1030;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
    } sample_t;

    typedef struct packed {
        logic [15:0] heading;
        logic [2:0]  sector;
    } heading_t;

    // One directed row: the sample and, where it is plain to see, the heading it must give.
    typedef struct packed {
        sample_t  smp;
        logic     typed;
        heading_t want;
    } dir_row_t;

    // Arctangent of 2^-i in degrees at scale 2^-22.
    localparam longint ATAN_DEG [24] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    logic signed [15:0] i_accel_x = '0;
    logic signed [15:0] i_accel_y = '0;
    logic signed [15:0] i_mag_x = '0;
    logic signed [15:0] i_mag_y = '0;
    logic signed [15:0] i_mag_z = '0;
    logic               o_stall;
    logic               o_valid;
    logic [15:0]        o_heading_deg;
    logic [2:0]         o_sector_index;

    heading_t pending_headings[$];
    int       mismatches = 0;

    tilt_compensated_compass_heading #(.CORDIC_STEPS(ROT_STEPS)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_accel_x     (i_accel_x),
        .i_accel_y     (i_accel_y),
        .i_mag_x       (i_mag_x),
        .i_mag_y       (i_mag_y),
        .i_mag_z       (i_mag_z),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_heading_deg (o_heading_deg),
        .o_sector_index(o_sector_index)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Generous ceiling on the whole run; a healthy run ends far sooner.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Floor of the square root of n, built one result bit at a time.
    function automatic longint floor_root(input longint n);
        longint r;
        r = 0;
        for (int b = 14; b >= 0; b--) begin
            if ((r | (64'sd1 << b)) * (r | (64'sd1 << b)) <= n) begin
                r = r | (64'sd1 << b);
            end
        end
        return r;
    endfunction

    function automatic longint clamp_g(input logic signed [15:0] a);
        longint v;
        v = longint'(a);
        if (v > ONE_Q14) v = ONE_Q14;
        if (v < -ONE_Q14) v = -ONE_Q14;
        return v;
    endfunction

    // Works out the heading and compass sector that one sensor sample must produce.
    function automatic heading_t predict_heading(input sample_t s);
        longint   sp, sr, cp, cr, mx, my, mz, x, y, z, dx, dy;
        int       steps;
        heading_t res;
        sp = clamp_g(s.ax);
        sr = clamp_g(s.ay);
        mx = longint'(s.mx);
        my = longint'(s.my);
        mz = longint'(s.mz);
        cp = floor_root((64'sd1 << 28) - sp * sp);
        cr = floor_root((64'sd1 << 28) - sr * sr);
        // Tilt-compensated horizontal field, exact at scale 2^-40.
        x = (mx * cp + mz * sp) * ONE_Q14;
        y = mx * sr * sp + my * cr * ONE_Q14 - mz * sr * cp;
        if (x == 0 && y == 0) begin
            z = 0;
        end else begin
            z = 0;
            // A vector in the left half plane is flipped and starts from 180 degrees.
            if (x < 0) begin
                x = -x;
                y = -y;
                z = 64'sd180 <<< 22;
            end
            steps = (ROT_STEPS > 24) ? 24 : ROT_STEPS;
            for (int i = 0; i < steps; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_DEG[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_DEG[i];
                end
            end
            if (z < 0) z = z + (64'sd360 <<< 22);
            z = (z + (64'sd1 << 14)) >>> 15;
            if (z > 46079) z = 46079;
        end
        res.heading = z[15:0];
        res.sector  = 3'((res.heading / 16'd5760 + 16'd4) % 16'd8);
        return res;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [15:0] rand_accel();
        int r;
        r = $urandom_range(0, 9);
        // Mostly a physically sensible tilt, sometimes anything the field allows.
        if (r < 7) return 16'($signed($urandom_range(0, 32768)) - 16384);
        return 16'($urandom);
    endfunction

    function automatic logic signed [15:0] rand_mag();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 16'($signed($urandom_range(0, 64)) - 32);
        return 16'($urandom);
    endfunction

    // Presents one request, leaving valid high across back-to-back requests, and
    // records what it must produce once the pipeline accepts it.
    task automatic send_request(input sample_t s, input logic typed, input heading_t want);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_accel_x <= s.ax;
        i_accel_y <= s.ay;
        i_mag_x   <= s.mx;
        i_mag_y   <= s.my;
        i_mag_z   <= s.mz;
        i_valid   <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        pending_headings.push_back(typed ? want : predict_heading(s));
    endtask

    // Output side: stall in random bursts, with quiet stretches in between.
    initial begin
        int len;
        @(posedge i_rst_n);
        forever begin
            len = idle_len();
            if (len > 0) begin
                i_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    // Every result that leaves the block is matched against the oldest expectation.
    always @(posedge i_clk) begin
        heading_t exp_h;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_headings.size() == 0) begin
                report_mismatch("unexpected result", o_heading_deg, -1);
            end else begin
                exp_h = pending_headings.pop_front();
                if (o_heading_deg !== exp_h.heading)
                    report_mismatch("heading_deg", o_heading_deg, exp_h.heading);
                if (o_sector_index !== exp_h.sector)
                    report_mismatch("sector_index", o_sector_index, exp_h.sector);
            end
        end
    end

    initial begin
        // Directed rows. A zero magnetic field must read 0 degrees in sector 4 whatever
        // the tilt, including accelerometer values far past the 1 g clamp.
        dir_row_t dir_rows [16] = '{
            '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd0, 3'd4}},
            '{'{-16'sd32768, 16'sd32767, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd0, 3'd4}},
            '{'{16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd0, 3'd4}},
            // Level, field pointing straight back: the left half-plane flip gives 180.
            '{'{16'sd0, 16'sd0, -16'sd4096, 16'sd0, 16'sd0}, 1'b1, '{16'd23040, 3'd0}},
            '{'{16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0}, 1'b0, '0},
            '{'{16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd0}, 1'b0, '0},
            '{'{16'sd0, 16'sd0, 16'sd0, -16'sd4096, 16'sd0}, 1'b0, '0},
            // Just below the positive axis: rounding may reach 360 and must saturate.
            '{'{16'sd0, 16'sd0, 16'sd32767, -16'sd1, 16'sd0}, 1'b0, '0},
            '{'{16'sd0, 16'sd0, -16'sd32768, -16'sd1, 16'sd0}, 1'b0, '0},
            '{'{16'sd16384, 16'sd16384, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0},
            '{'{-16'sd16384, -16'sd16384, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0},
            '{'{16'sd32767, -16'sd32768, 16'sd1000, -16'sd2000, 16'sd3000}, 1'b0, '0},
            '{'{16'sd16385, -16'sd16385, -16'sd1, 16'sd1, 16'sd1}, 1'b0, '0},
            '{'{16'sd8192, -16'sd8192, 16'sd0, 16'sd0, 16'sd4096}, 1'b0, '0},
            '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096}, 1'b0, '0},
            '{'{16'sd11585, 16'sd0, 16'sd2896, 16'sd2896, 16'sd0}, 1'b0, '0}
        };
        sample_t s;
        int      waited;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_request(dir_rows[k].smp, dir_rows[k].typed, dir_rows[k].want);
        end

        for (int n = 0; n < RAND_REQS; n++) begin
            // Midway, hold off new requests until the pipeline has fully drained.
            if (n == RAND_REQS / 2) begin
                i_valid <= 1'b0;
                while (pending_headings.size() != 0) @(posedge i_clk);
            end
            s.ax = rand_accel();
            s.ay = rand_accel();
            s.mx = rand_mag();
            s.my = rand_mag();
            s.mz = rand_mag();
            send_request(s, 1'b0, '0);
        end
        i_valid <= 1'b0;

        waited = 0;
        while (pending_headings.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0 && pending_headings.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
